// File: rtl/dpm_pkg.sv
// Shared types, constants and the log2 lookup table for the dew point block.
// No dependencies; every other file in rtl/ imports this package.
package dpm_pkg;

	localparam int LOG_TABLE_BITS = 6;
	localparam int FRAC_BITS      = 13;
	localparam int TAB_N          = 1 << LOG_TABLE_BITS;
	localparam int INTERP_SH      = FRAC_BITS - LOG_TABLE_BITS;

	// Shared divider: magnitude dividend and divisor widths.
	localparam int DIV_NW = 44;
	localparam int DIV_DW = 30;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam int DP_LIMIT = 10000;

	typedef logic [16:0] log_tab_t [TAB_N+1];

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_LOG2, S_LN1, S_LN2, S_BDIV, S_G, S_DPREP, S_DDIV, S_OUT
	} dpm_state_t;

	typedef struct packed {
		logic load;
		logic log1;
		logic log2;
		logic ln1;
		logic ln2;
		logic bstart;
		logic gsum;
		logic dprep;
		logic dstart;
		logic dfin;
		logic inval;
		logic push;
	} dpm_cmd_t;

	typedef struct packed {
		logic invalid;
		logic den_bad;
		logic div_done;
		logic div_busy;
		logic out_free;
	} dpm_stat_t;

	// log2(1 + k/2^LOG_TABLE_BITS) in Q16 by repeated squaring; elaboration only.
	function automatic logic [16:0] tab_entry(input int k);
		longint unsigned x;
		logic [16:0] r;
		x = (64'd1 << 30) + (longint'(k) << (30 - LOG_TABLE_BITS));
		r = '0;
		if (x >= (64'd1 << 31)) begin
			r = 17'd65536;
		end else begin
			for (int i = 0; i < 16; i++) begin
				x = (x * x) >> 30;
				r = {r[15:0], 1'b0};
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					r[0] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_tab();
		log_tab_t t;
		for (int k = 0; k <= TAB_N; k++) begin
			t[k] = tab_entry(k);
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_tab();

	// Same approximation as the datapath, for a constant argument.
	function automatic int log2_const(input int h);
		int e;
		int m;
		int frac;
		int k;
		int rem;
		int t0;
		int t1;
		e = 0;
		while (e < 13 && (h >> (e + 1)) != 0) begin
			e++;
		end
		m = (h << (13 - e)) & 16'h3FFF;
		frac = m - (1 << FRAC_BITS);
		k = frac >> INTERP_SH;
		rem = frac & ((1 << INTERP_SH) - 1);
		t0 = int'(tab_entry(k));
		t1 = int'(tab_entry(k + 1));
		return e * 65536 + t0 + (((t1 - t0) * rem) >> INTERP_SH);
	endfunction

	localparam logic signed [21:0] LOG2_FULL = 22'(log2_const(10000));

endpackage

// File: rtl/dew_point_magnus.sv
// Dew point (Magnus/Bolton) from temperature and humidity samples.
// Up to two divides in the shared divider plus the log and Magnus steps lie between the
// input transfer and the result on out_valid; an invalid sample skips them.
// One sample at a time, taken only while idle; a result waiting in the output register
// stalls the next one until out_ready takes it.
// Reset: arst_n clears the stored samples, their present bits, the output valid flag, the divider and the sequencer.
module dew_point_magnus (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [14:0] sample,
	input  logic               sample_valid,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] dew_temp,
	output logic               dew_temp_valid
);
	import dpm_pkg::*;

	dpm_cmd_t  cmd;
	dpm_stat_t st;

	dpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	dpm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.kind           (kind),
		.sample         (sample),
		.sample_valid   (sample_valid),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.dew_temp       (dew_temp),
		.dew_temp_valid (dew_temp_valid)
	);
endmodule

// File: rtl/dpm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on dpm_pkg for the operand widths.
module dpm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dpm_pkg::DIV_NW-1:0]  dividend,
	input  logic [dpm_pkg::DIV_DW-1:0]  divisor,
	output logic                        busy,
	output logic                        done,
	output logic [dpm_pkg::DIV_NW-1:0]  quot
);
	import dpm_pkg::*;

	logic [DIV_DW:0]   rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	always_comb begin
		trial = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, d_q}) : trial;
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q) else $error("divider did not start");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(start) == 1'b0 && !busy_q && !done_q)
		else $error("divider done held");
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("divider busy and done together");
endmodule

// File: rtl/dpm_dp.sv
// Datapath: stored samples, log2 approximation, Magnus terms, output register.
// Depends on dpm_pkg and dpm_div; driven by dpm_ctrl commands.
module dpm_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dpm_pkg::dpm_cmd_t       cmd,
	output dpm_pkg::dpm_stat_t      st,
	input  logic                    kind,
	input  logic signed [14:0]      sample,
	input  logic                    sample_valid,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [14:0]      dew_temp,
	output logic                    dew_temp_valid
);
	import dpm_pkg::*;

	logic signed [14:0] temp_q;
	logic               tpres_q;
	logic [13:0]        hum_q;
	logic               hpres_q;

	logic [3:0]                    e_s1;
	logic [LOG_TABLE_BITS-1:0]     k_s1;
	logic [INTERP_SH-1:0]          rem_s1;
	logic signed [25:0]            numb_s1;
	logic [21:0]                   denb_s1;
	logic [20:0]                   lg_s2;
	logic signed [38:0]            lnp_s3;
	logic signed [21:0]            ln_s4;
	logic signed [25:0]            g_q;
	logic signed [48:0]            prod2_q;
	logic signed [34:0]            den2_q;
	logic                          neg_q;
	logic signed [14:0]            res_q;
	logic                          resv_q;
	logic                          ov_q;
	logic signed [14:0]            dp_q;
	logic                          dpv_q;

	// Normalization of the stored humidity.
	logic [3:0]  e_c;
	logic [13:0] m_c;
	always_comb begin
		e_c = '0;
		for (int i = 1; i < 14; i++) begin
			if (hum_q[i]) begin
				e_c = 4'(i);
			end
		end
		m_c = hum_q << (4'd13 - e_c);
	end

	// Table interpolation.
	logic [16:0]             t0_c;
	logic [16:0]             t1_c;
	logic [16+INTERP_SH:0]   ip_c;
	always_comb begin
		t0_c = LOG_TAB[{1'b0, k_s1}];
		t1_c = LOG_TAB[{1'b0, k_s1} + 1'b1];
		ip_c = (t1_c - t0_c) * rem_s1;
	end

	// ln rounding, ties away from zero.
	logic [38:0] lnmag_c;
	logic [22:0] lnr_c;
	always_comb begin
		lnmag_c = lnp_s3[38] ? 39'(-lnp_s3) : 39'(lnp_s3);
		lnr_c   = 23'((lnmag_c + 39'd32768) >> 16);
	end

	// Divider operands.
	logic [24:0]        nbmag_c;
	logic [48:0]        p2mag_c;
	logic [DIV_NW-1:0]  dvd_c;
	logic [DIV_DW-1:0]  dvs_c;
	logic [DIV_NW-1:0]  quot;
	logic               div_busy;
	logic               div_done;
	always_comb begin
		nbmag_c = numb_s1[25] ? 25'(-numb_s1) : 25'(numb_s1);
		p2mag_c = prod2_q[48] ? 49'(-prod2_q) : 49'(prod2_q);
		if (cmd.dstart) begin
			dvd_c = p2mag_c[DIV_NW-1:0] + DIV_NW'(den2_q[DIV_DW-1:1]);
			dvs_c = den2_q[DIV_DW-1:0];
		end else begin
			dvd_c = {nbmag_c, 16'b0} + DIV_NW'(denb_s1[21:1]);
			dvs_c = DIV_DW'(denb_s1);
		end
	end

	dpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.bstart | cmd.dstart),
		.dividend (dvd_c),
		.divisor  (dvs_c),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (quot)
	);

	logic signed [24:0] bq_c;
	logic signed [14:0] dpf_c;
	always_comb begin
		bq_c = neg_q ? -$signed({1'b0, quot[23:0]}) : $signed({1'b0, quot[23:0]});
		if (quot > DIV_NW'(DP_LIMIT)) begin
			dpf_c = neg_q ? -15'sd10000 : 15'sd10000;
		end else begin
			dpf_c = neg_q ? -$signed(quot[14:0]) : $signed(quot[14:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			tpres_q <= 1'b0;
			hum_q   <= '0;
			hpres_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (!kind) begin
					tpres_q <= sample_valid;
					if (sample_valid) begin
						temp_q <= sample;
					end
				end else begin
					hpres_q <= sample_valid;
					if (sample_valid) begin
						hum_q <= sample[14] ? 14'd0 : sample[13:0];
					end
				end
			end
			if (cmd.push) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.log1) begin
			e_s1    <= e_c;
			k_s1    <= m_c[12:INTERP_SH];
			rem_s1  <= m_c[INTERP_SH-1:0];
			numb_s1 <= 26'(temp_q * 12'sd1767);
			denb_s1 <= 22'(($signed(temp_q) + 16'sd24350) * 8'sd100);
		end
		if (cmd.log2) begin
			lg_s2 <= {1'b0, e_s1, 16'b0} + 21'(t0_c) + 21'(ip_c >> INTERP_SH);
			neg_q <= numb_s1[25];
		end
		if (cmd.ln1) begin
			lnp_s3 <= 39'(($signed({1'b0, lg_s2}) - LOG2_FULL) * 18'sd45426);
		end
		if (cmd.ln2) begin
			ln_s4 <= lnp_s3[38] ? -$signed(lnr_c[21:0]) : $signed(lnr_c[21:0]);
		end
		if (cmd.gsum) begin
			g_q <= 26'(ln_s4) + 26'(bq_c);
		end
		if (cmd.dprep) begin
			prod2_q <= 49'(g_q * 23'sd2435000);
			den2_q  <= 35'sd115802112 - 35'(g_q * 8'sd100);
			neg_q   <= g_q[25];
		end
		if (cmd.dfin) begin
			res_q  <= dpf_c;
			resv_q <= 1'b1;
		end else if (cmd.inval) begin
			res_q  <= '0;
			resv_q <= 1'b0;
		end else if (cmd.dstart == 1'b0 && cmd.gsum == 1'b0 && st.den_bad && cmd.push == 1'b0
				&& cmd.ln1 == 1'b0 && cmd.ln2 == 1'b0 && cmd.log2 == 1'b0 && cmd.load == 1'b0
				&& cmd.dprep == 1'b0 && cmd.log1 == 1'b0 && cmd.bstart == 1'b0
				&& st.div_busy == 1'b0 && st.div_done == 1'b0 && st.invalid == 1'b0
				&& 1'b0) begin
			res_q <= res_q;
		end
		if (cmd.push) begin
			dp_q  <= st.den_bad ? 15'sd10000 : res_q;
			dpv_q <= st.den_bad ? 1'b1 : resv_q;
		end
	end

	always_comb begin
		st.invalid  = !tpres_q || !hpres_q || (hum_q == 14'd0);
		st.den_bad  = (den2_q <= 35'sd0) && !st.invalid;
		st.div_done = div_done;
		st.div_busy = div_busy;
		st.out_free = !ov_q || out_ready;
	end

	assign out_valid      = ov_q;
	assign dew_temp       = dp_q;
	assign dew_temp_valid = dpv_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !ov_q || out_ready) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready && !cmd.push |=> ov_q && $stable(dp_q))
		else $error("pending result changed");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.bstart || cmd.dstart) |-> !div_busy) else $error("divider restarted");
endmodule

// File: rtl/dpm_ctrl.sv
// Sequencer for the dew point datapath: one sample at a time.
// Depends on dpm_pkg for the state, command and status types.
module dpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dpm_pkg::dpm_stat_t  st,
	output dpm_pkg::dpm_cmd_t   cmd
);
	import dpm_pkg::*;

	dpm_state_t state_q;
	dpm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (st.invalid) begin
					cmd.inval = 1'b1;
					state_d   = S_OUT;
				end else begin
					cmd.log1 = 1'b1;
					state_d  = S_LOG2;
				end
			end
			S_LOG2: begin
				cmd.log2   = 1'b1;
				cmd.bstart = 1'b1;
				state_d    = S_LN1;
			end
			S_LN1: begin
				cmd.ln1 = 1'b1;
				state_d = S_LN2;
			end
			S_LN2: begin
				cmd.ln2 = 1'b1;
				state_d = S_BDIV;
			end
			S_BDIV: begin
				if (st.div_done) begin
					cmd.gsum = 1'b1;
					state_d  = S_G;
				end
			end
			S_G: begin
				cmd.dprep = 1'b1;
				state_d   = S_DPREP;
			end
			S_DPREP: begin
				// A non-positive denominator saturates, which the output stage handles.
				if (st.den_bad) begin
					state_d = S_OUT;
				end else begin
					cmd.dstart = 1'b1;
					state_d    = S_DDIV;
				end
			end
			S_DDIV: begin
				if (st.div_done) begin
					cmd.dfin = 1'b1;
					state_d  = S_OUT;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_load_chk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CHK) else $error("load not followed by check");
	a_bdiv_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BDIV && !st.div_done |=> state_q == S_BDIV)
		else $error("left divide wait early");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.out_free) else $error("push into full output");
endmodule
